### rtl/aktl_pkg.sv
// ----------------------------------------------------------------------------
// Access key table lock package
// Request, display, status and reader mode codes, and the sequencer types.
// ----------------------------------------------------------------------------
package aktl_pkg;

    localparam int unsigned KEY_W         = 64;
    localparam int unsigned PRELOAD_COUNT = 6;

    localparam logic [2:0] FUNC_PRESENT    = 3'd0;
    localparam logic [2:0] FUNC_CLOSE      = 3'd1;
    localparam logic [2:0] FUNC_REGISTER   = 3'd2;
    localparam logic [2:0] FUNC_UNREGISTER = 3'd3;
    localparam logic [2:0] FUNC_CYCLE      = 3'd4;

    localparam logic [1:0] DISP_NONE   = 2'd0;
    localparam logic [1:0] DISP_OPEN   = 2'd1;
    localparam logic [1:0] DISP_ERROR  = 2'd2;
    localparam logic [1:0] DISP_CLOSED = 2'd3;

    localparam logic [2:0] STS_DONE      = 3'd0;
    localparam logic [2:0] STS_REJECTED  = 3'd1;
    localparam logic [2:0] STS_DUPLICATE = 3'd2;
    localparam logic [2:0] STS_FULL      = 3'd3;
    localparam logic [2:0] STS_NOT_FOUND = 3'd4;
    localparam logic [2:0] STS_UNKNOWN   = 3'd5;

    localparam logic [1:0] MODE_OPEN       = 2'd0;
    localparam logic [1:0] MODE_REGISTER   = 2'd1;
    localparam logic [1:0] MODE_UNREGISTER = 2'd2;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DRAIN,
        S_FINISH
    } state_t;

    typedef enum logic [1:0] {
        OP_CHECK,
        OP_REGISTER,
        OP_UNREGISTER
    } op_t;

endpackage

### rtl/access_key_table_lock_core.sv
// ----------------------------------------------------------------------------
// Access key table lock core
// Key table in a single-port synchronous memory, scanned at most once per request.
// ----------------------------------------------------------------------------
// One request is taken at a time. Present, register and unregister requests
// with a nonzero key scan the whole table through the memory's single read
// port, one slot per cycle, and pass through a drain state before the
// result; close, cycle mode, unknown requests and zero keys skip the scan.
// A new request is accepted as soon as the sequencer is idle, while the
// previous result may still wait in the output register. No clearing pass
// is needed after reset: per-slot valid bits make unwritten slots read as
// their preload value.
module access_key_table_lock_core #(
    parameter int unsigned KEY_SLOTS = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // [63:0] key_value
    input  logic [2:0]  s_tuser,   // [2:0] func
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata    // [1:0] display, [4:2] status, [5] lock_open,
                                   // [7:6] reader_mode_now
);

    localparam int unsigned IDX_W = $clog2(KEY_SLOTS);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(KEY_SLOTS - 1);

    aktl_pkg::state_t state_reg;
    aktl_pkg::state_t state_next;

    aktl_pkg::op_t         op_reg;
    logic                  imm_reg;
    logic [1:0]            imm_disp_reg;
    logic [2:0]            imm_status_reg;
    logic [63:0]           key_reg;
    logic                  open_reg;
    logic [1:0]            mode_reg;

    logic [IDX_W-1:0]      rd_addr_reg;
    logic                  rd_pend_reg;
    logic [IDX_W-1:0]      rd_idx_reg;
    logic [63:0]           rd_data_reg;
    logic                  rd_valid_reg;

    logic                  found_reg;
    logic [IDX_W-1:0]      found_idx_reg;
    logic                  empty_reg;
    logic [IDX_W-1:0]      empty_idx_reg;

    logic                  m_tvalid_reg;
    logic [7:0]            m_tdata_reg;

    logic [63:0]           key_mem [KEY_SLOTS];
    logic [KEY_SLOTS-1:0]  slot_valid_reg;

    logic                  accept;
    logic                  rd_en;
    logic                  fin_fire;
    logic                  out_free;

    aktl_pkg::op_t         acc_op;
    logic                  acc_imm;
    logic [1:0]            acc_disp;
    logic [2:0]            acc_status;

    logic [63:0]           entry;
    logic [1:0]            fin_disp;
    logic [2:0]            fin_status;
    logic                  fin_open;
    logic                  wr_en;
    logic [IDX_W-1:0]      wr_idx;
    logic [63:0]           wr_data;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            aktl_pkg::S_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = acc_imm ? aktl_pkg::S_FINISH : aktl_pkg::S_SCAN;
                end
            end
            aktl_pkg::S_SCAN:
            begin
                if (rd_addr_reg == LAST_IDX)
                begin
                    state_next = aktl_pkg::S_DRAIN;
                end
            end
            aktl_pkg::S_DRAIN:
            begin
                state_next = aktl_pkg::S_FINISH;
            end
            aktl_pkg::S_FINISH:
            begin
                if (out_free)
                begin
                    state_next = aktl_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = aktl_pkg::S_IDLE;
            end
        endcase
    end

    // sequencer outputs
    always_comb
    begin
        s_tready = 1'b0;
        rd_en    = 1'b0;
        fin_fire = 1'b0;
        case (state_reg)
            aktl_pkg::S_IDLE:   s_tready = 1'b1;
            aktl_pkg::S_SCAN:   rd_en    = 1'b1;
            aktl_pkg::S_DRAIN:  rd_en    = 1'b0;
            aktl_pkg::S_FINISH: fin_fire = out_free;
            default:            s_tready = 1'b0;
        endcase
    end

    assign out_free = !m_tvalid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;

    // decode request at acceptance
    always_comb
    begin
        acc_op     = aktl_pkg::OP_CHECK;
        acc_imm    = 1'b1;
        acc_disp   = aktl_pkg::DISP_NONE;
        acc_status = aktl_pkg::STS_DONE;
        case (s_tuser)
            aktl_pkg::FUNC_PRESENT:
            begin
                if (mode_reg == aktl_pkg::MODE_REGISTER)
                begin
                    acc_op = aktl_pkg::OP_REGISTER;
                end
                else if (mode_reg == aktl_pkg::MODE_UNREGISTER)
                begin
                    acc_op = aktl_pkg::OP_UNREGISTER;
                end
                else
                begin
                    acc_op = aktl_pkg::OP_CHECK;
                end
            end
            aktl_pkg::FUNC_REGISTER:   acc_op = aktl_pkg::OP_REGISTER;
            aktl_pkg::FUNC_UNREGISTER: acc_op = aktl_pkg::OP_UNREGISTER;
            default:                   acc_op = aktl_pkg::OP_CHECK;
        endcase

        case (s_tuser)
            aktl_pkg::FUNC_PRESENT, aktl_pkg::FUNC_REGISTER, aktl_pkg::FUNC_UNREGISTER:
            begin
                acc_imm = (s_tdata == 64'd0);
                case (acc_op)
                    aktl_pkg::OP_REGISTER:   acc_status = aktl_pkg::STS_REJECTED;
                    aktl_pkg::OP_UNREGISTER: acc_status = aktl_pkg::STS_NOT_FOUND;
                    default:
                    begin
                        acc_disp   = aktl_pkg::DISP_ERROR;
                        acc_status = aktl_pkg::STS_REJECTED;
                    end
                endcase
            end
            aktl_pkg::FUNC_CLOSE: acc_disp   = aktl_pkg::DISP_CLOSED;
            aktl_pkg::FUNC_CYCLE: acc_status = aktl_pkg::STS_DONE;
            default:              acc_status = aktl_pkg::STS_UNKNOWN;
        endcase
    end

    // slot contents: unwritten slots hold their preload value
    assign entry = rd_valid_reg ? rd_data_reg
                 : ((32'(rd_idx_reg) < aktl_pkg::PRELOAD_COUNT) ? 64'(rd_idx_reg) : 64'd0);

    // result and write-back
    always_comb
    begin
        fin_disp   = imm_disp_reg;
        fin_status = imm_status_reg;
        fin_open   = open_reg;
        wr_en      = 1'b0;
        wr_idx     = found_idx_reg;
        wr_data    = 64'd0;
        if (!imm_reg)
        begin
            fin_disp   = aktl_pkg::DISP_NONE;
            fin_status = aktl_pkg::STS_DONE;
            case (op_reg)
                aktl_pkg::OP_REGISTER:
                begin
                    if (found_reg)
                    begin
                        fin_status = aktl_pkg::STS_DUPLICATE;
                    end
                    else if (empty_reg)
                    begin
                        wr_en   = 1'b1;
                        wr_idx  = empty_idx_reg;
                        wr_data = key_reg;
                    end
                    else
                    begin
                        fin_status = aktl_pkg::STS_FULL;
                    end
                end
                aktl_pkg::OP_UNREGISTER:
                begin
                    if (found_reg)
                    begin
                        wr_en = 1'b1;
                    end
                    else
                    begin
                        fin_status = aktl_pkg::STS_NOT_FOUND;
                    end
                end
                default:
                begin
                    if (found_reg)
                    begin
                        fin_open = 1'b1;
                        fin_disp = aktl_pkg::DISP_OPEN;
                    end
                    else
                    begin
                        fin_disp   = aktl_pkg::DISP_ERROR;
                        fin_status = aktl_pkg::STS_REJECTED;
                    end
                end
            endcase
        end
    end

    // key memory
    always_ff @(posedge clk)
    begin
        if (fin_fire && wr_en)
        begin
            key_mem[wr_idx] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= key_mem[rd_addr_reg];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_valid_reg <= '0;
            rd_valid_reg   <= 1'b0;
        end
        else
        begin
            if (fin_fire && wr_en)
            begin
                slot_valid_reg[wr_idx] <= 1'b1;
            end
            if (rd_en)
            begin
                rd_valid_reg <= slot_valid_reg[rd_addr_reg];
            end
        end
    end

    // control and scan state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= aktl_pkg::S_IDLE;
            op_reg        <= aktl_pkg::OP_CHECK;
            imm_reg       <= 1'b0;
            open_reg      <= 1'b0;
            mode_reg      <= aktl_pkg::MODE_OPEN;
            rd_addr_reg   <= '0;
            rd_pend_reg   <= 1'b0;
            found_reg     <= 1'b0;
            empty_reg     <= 1'b0;
            m_tvalid_reg  <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            rd_pend_reg <= rd_en;
            if (rd_en)
            begin
                rd_addr_reg <= rd_addr_reg + 1'b1;
            end

            if (accept)
            begin
                op_reg      <= acc_op;
                imm_reg     <= acc_imm;
                rd_addr_reg <= '0;
                found_reg   <= 1'b0;
                empty_reg   <= 1'b0;
                if (s_tuser == aktl_pkg::FUNC_CLOSE)
                begin
                    open_reg <= 1'b0;
                end
                if (s_tuser == aktl_pkg::FUNC_CYCLE)
                begin
                    case (mode_reg)
                        aktl_pkg::MODE_OPEN:     mode_reg <= aktl_pkg::MODE_REGISTER;
                        aktl_pkg::MODE_REGISTER: mode_reg <= aktl_pkg::MODE_UNREGISTER;
                        default:                 mode_reg <= aktl_pkg::MODE_OPEN;
                    endcase
                end
            end

            if (rd_pend_reg)
            begin
                if (!found_reg && entry == key_reg)
                begin
                    found_reg <= 1'b1;
                end
                if (!empty_reg && entry == 64'd0)
                begin
                    empty_reg <= 1'b1;
                end
            end

            if (fin_fire)
            begin
                open_reg     <= fin_open;
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            key_reg        <= s_tdata;
            imm_disp_reg   <= acc_disp;
            imm_status_reg <= acc_status;
        end
        if (rd_en)
        begin
            rd_idx_reg <= rd_addr_reg;
        end
        if (rd_pend_reg)
        begin
            if (!found_reg && entry == key_reg)
            begin
                found_idx_reg <= rd_idx_reg;
            end
            if (!empty_reg && entry == 64'd0)
            begin
                empty_idx_reg <= rd_idx_reg;
            end
        end
        if (fin_fire)
        begin
            m_tdata_reg <= {mode_reg, fin_open, fin_status, fin_disp};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule
